// ----- design/bcs_pkg.sv -----
package bcs_pkg;

   localparam int MAX_CAPTURES = 64;
   localparam int IDX_W = $clog2(MAX_CAPTURES);
   localparam int CNT_W = $clog2(MAX_CAPTURES + 1);

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_TAKE  = 2'd2;

   typedef struct packed {
      logic [15:0] move;
      logic [11:0] gain;
      logic [11:0] aggr;
   } bcs_entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             load_en;
      bcs_entry_type    load_entry;
      logic [CNT_W-1:0] take_ptr;
      logic [CNT_W-1:0] entry_count;
      logic             swap_en;
      logic [IDX_W-1:0] swap_idx;
      bcs_entry_type    swap_entry;
   } bcs_cmd_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic             live;
      logic             found;
      bcs_entry_type    best;
      logic [IDX_W-1:0] best_idx;
      bcs_entry_type    head;
   } bcs_token_type;

endpackage

// ----- design/bcs_req_if.sv -----
interface bcs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] move_code;
   logic [11:0] victim_gain;
   logic [11:0] attacker_value;

   modport source (output valid, operation, move_code, victim_gain, attacker_value,
                   input ready);
   modport sink (input valid, operation, move_code, victim_gain, attacker_value,
                 output ready);
endinterface

// ----- design/bcs_rsp_if.sv -----
interface bcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] chosen_move;
   logic [11:0] chosen_gain;
   logic        found;
   logic        store_full;

   modport source (output valid, chosen_move, chosen_gain, found, store_full,
                   input ready);
   modport sink (input valid, chosen_move, chosen_gain, found, store_full,
                 output ready);
endinterface

// ----- design/bcs_cell.sv -----
module bcs_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bcs_pkg::CNT_W-1:0]  cell_index,
   input  bcs_pkg::bcs_cmd_type       cmd,
   input  bcs_pkg::bcs_token_type     token_prev,
   output bcs_pkg::bcs_token_type     token_out
);

   bcs_pkg::bcs_entry_type entry_ff;
   bcs_pkg::bcs_entry_type entry_in;
   bcs_pkg::bcs_token_type token_ff;
   bcs_pkg::bcs_token_type token_in;
   logic                   in_range;
   logic                   better;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.load_en && (cmd.entry_count == cell_index)) begin
         entry_in = cmd.load_entry;
      end else if (cmd.swap_en && (cmd.swap_idx == cell_index[bcs_pkg::IDX_W-1:0])) begin
         entry_in = cmd.swap_entry;
      end
   end

   assign in_range = (cell_index >= cmd.take_ptr) && (cell_index < cmd.entry_count);
   assign better   = (entry_ff.gain > token_prev.best.gain) ||
                     ((entry_ff.gain == token_prev.best.gain) &&
                      (entry_ff.aggr < token_prev.best.aggr));

   always_comb begin
      token_in = token_prev;
      if (token_prev.live && in_range) begin
         if (cell_index == cmd.take_ptr) begin
            token_in.head = entry_ff;
         end
         if (!token_prev.found || better) begin
            token_in.found    = 1'b1;
            token_in.best     = entry_ff;
            token_in.best_idx = cell_index[bcs_pkg::IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in;
      end
   end

   assign token_out = token_ff;

endmodule

// ----- design/best_capture_selector_core.sv -----
// clear and load: the next transaction is taken in the following cycle
// take: the scan token walks the row of entry cells one cell per cycle; its result is held,
// then registered as the response once the output is free; one take in flight at a time
// throughput: loads and clears one per cycle while no take is in flight; a new take waits for the last response
// reset: count, take position, overflow flag and handshake state clear; entries stay
module best_capture_selector_core (
   input  logic      clock,
   input  logic      reset,
   bcs_req_if.sink   req_chan,
   bcs_rsp_if.source rsp_chan
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                  state_ff;
   logic [1:0]                  state_in;
   logic [bcs_pkg::CNT_W-1:0]   count_ff;
   logic [bcs_pkg::CNT_W-1:0]   count_in;
   logic [bcs_pkg::CNT_W-1:0]   tp_ff;
   logic [bcs_pkg::CNT_W-1:0]   tp_in;
   logic                        ovf_ff;
   logic                        ovf_in;
   bcs_pkg::bcs_token_type      hold_ff;
   bcs_pkg::bcs_token_type      hold_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [15:0]                 rsp_move_ff;
   logic [15:0]                 rsp_move_in;
   logic [11:0]                 rsp_gain_ff;
   logic [11:0]                 rsp_gain_in;
   logic                        rsp_found_ff;
   logic                        rsp_found_in;
   logic                        rsp_full_ff;
   logic                        rsp_full_in;
   logic                        accept;
   logic                        rsp_free;
   logic                        full;
   bcs_pkg::bcs_cmd_type        cmd;
   bcs_pkg::bcs_token_type      token_start;
   bcs_pkg::bcs_token_type      chain [0:bcs_pkg::MAX_CAPTURES];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign full           = (count_ff == bcs_pkg::CNT_W'(bcs_pkg::MAX_CAPTURES));

   // scan token entering the first cell
   always_comb begin
      token_start      = '0;
      token_start.live = accept && (req_chan.operation == bcs_pkg::OP_TAKE);
   end

   assign chain[0] = token_start;

   always_comb begin
      cmd                  = '0;
      cmd.load_en          = accept && (req_chan.operation == bcs_pkg::OP_LOAD) && !full;
      cmd.load_entry.move  = req_chan.move_code;
      cmd.load_entry.gain  = req_chan.victim_gain;
      cmd.load_entry.aggr  = req_chan.attacker_value;
      cmd.take_ptr         = tp_ff;
      cmd.entry_count      = count_ff;
      cmd.swap_en          = (state_ff == ST_FINISH) && rsp_free && hold_ff.found;
      cmd.swap_idx         = hold_ff.best_idx;
      cmd.swap_entry       = hold_ff.head;
   end

   genvar gi;
   generate
      for (gi = 0; gi < bcs_pkg::MAX_CAPTURES; gi++) begin : g_cell
         bcs_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (bcs_pkg::CNT_W'(gi)),
            .cmd        (cmd),
            .token_prev (chain[gi]),
            .token_out  (chain[gi+1])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      tp_in        = tp_ff;
      ovf_in       = ovf_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_move_in  = rsp_move_ff;
      rsp_gain_in  = rsp_gain_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.operation)
                  bcs_pkg::OP_CLEAR: begin
                     count_in = '0;
                     tp_in    = '0;
                     ovf_in   = 1'b0;
                  end
                  bcs_pkg::OP_LOAD: begin
                     if (full) begin
                        ovf_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  bcs_pkg::OP_TAKE: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (chain[bcs_pkg::MAX_CAPTURES].live) begin
               hold_in  = chain[bcs_pkg::MAX_CAPTURES];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_move_in  = hold_ff.found ? hold_ff.best.move : 16'd0;
               rsp_gain_in  = hold_ff.found ? hold_ff.best.gain : 12'd0;
               rsp_found_in = hold_ff.found;
               rsp_full_in  = ovf_ff;
               if (hold_ff.found) begin
                  tp_in = tp_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tp_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tp_ff        <= tp_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_ff      <= hold_in;
      rsp_move_ff  <= rsp_move_in;
      rsp_gain_ff  <= rsp_gain_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.chosen_move = rsp_move_ff;
   assign rsp_chan.chosen_gain = rsp_gain_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.store_full  = rsp_full_ff;

   a_tp_le_count: assert property (@(posedge clock) disable iff (reset)
      tp_ff <= count_ff)
      else $error("take position beyond entry count");

   a_count_le_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bcs_pkg::CNT_W'(bcs_pkg::MAX_CAPTURES))
      else $error("entry count beyond store depth");

   a_chain_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[bcs_pkg::MAX_CAPTURES].live |-> (state_ff == ST_SCAN))
      else $error("scan token left the row outside a scan");

   a_tp_advance: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && rsp_free && hold_ff.found) |=>
      (tp_ff == $past(tp_ff) + 1'b1))
      else $error("take position did not advance after a found capture");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside finish");

endmodule

// ----- tb/tb_best_capture_selector_core.sv -----
module tb_best_capture_selector_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int TARGET_ITEMS = 730;
   localparam int TAIL_ITEMS = 60;
   localparam int LONG_HOLD = 600;
   localparam int SETTLE_CYCLES = 2 * bcs_pkg::MAX_CAPTURES + 8;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] move;
      logic [11:0] gain;
      logic [11:0] aggr;
   } list_request_type;

   typedef struct packed {
      logic [15:0] move;
      logic [11:0] gain;
      logic        found;
      logic        full;
   } capture_pick_type;

   logic clock;
   logic reset;

   bcs_req_if req_bus();
   bcs_rsp_if rsp_bus();

   best_capture_selector_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   list_request_type request_queue[$];
   list_request_type current_request;
   capture_pick_type expected_picks[$];

   bcs_pkg::bcs_entry_type shadow_list[bcs_pkg::MAX_CAPTURES];
   int                     shadow_count;
   int                     shadow_taken;
   logic                   shadow_overflow;

   int total_items;
   int counted_items;
   int accepted_items;
   int gap_left;
   int hold_left;
   bit long_hold_done;
   int error_count;
   int picks_seen;
   int empty_picks;
   int dropped_loads;

   // mirror of the capture list, advanced once per accepted transaction
   task automatic track_request(input list_request_type r);
      int                     best;
      bcs_pkg::bcs_entry_type chosen;
      capture_pick_type       pick;
      case (r.op)
         bcs_pkg::OP_CLEAR: begin
            shadow_count = 0;
            shadow_taken = 0;
            shadow_overflow = 1'b0;
         end
         bcs_pkg::OP_LOAD: begin
            if (shadow_count >= bcs_pkg::MAX_CAPTURES) begin
               shadow_overflow = 1'b1;
               dropped_loads++;
            end else begin
               shadow_list[shadow_count] = {r.move, r.gain, r.aggr};
               shadow_count++;
            end
         end
         bcs_pkg::OP_TAKE: begin
            pick = '0;
            if (shadow_taken < shadow_count) begin
               best = shadow_taken;
               for (int i = shadow_taken + 1; i < shadow_count; i++) begin
                  if (shadow_list[i].gain > shadow_list[best].gain ||
                      (shadow_list[i].gain == shadow_list[best].gain &&
                       shadow_list[i].aggr < shadow_list[best].aggr))
                     best = i;
               end
               chosen = shadow_list[best];
               shadow_list[best] = shadow_list[shadow_taken];
               shadow_taken++;
               pick.move = chosen.move;
               pick.gain = chosen.gain;
               pick.found = 1'b1;
            end
            pick.full = shadow_overflow;
            expected_picks.push_back(pick);
         end
         default: begin
         end
      endcase
   endtask

   function automatic void queue_request(input logic [1:0] op, input logic [15:0] move,
                                         input logic [11:0] gain, input logic [11:0] aggr);
      request_queue.push_back({op, move, gain, aggr});
      if (op != OP_IGNORED)
         counted_items++;
   endfunction

   // narrow value range gives plenty of gain ties and full ties
   function automatic void queue_random_load(input bit tight);
      logic [11:0] gain;
      logic [11:0] aggr;
      gain = tight ? 12'($urandom_range(0, 3)) : 12'($urandom_range(0, 4095));
      aggr = tight ? 12'($urandom_range(0, 3)) : 12'($urandom_range(0, 4095));
      queue_request(bcs_pkg::OP_LOAD, 16'($urandom), gain, aggr);
   endfunction

   function automatic void queue_random_take();
      queue_request(bcs_pkg::OP_TAKE, 16'($urandom), 12'($urandom), 12'($urandom));
   endfunction

   function automatic void build_stimulus();
      int loads;
      bit tight;
      queue_request(bcs_pkg::OP_TAKE, 16'h0000, 12'h000, 12'h000);
      queue_request(OP_IGNORED, 16'hFFFF, 12'hFFF, 12'hFFF);
      queue_request(bcs_pkg::OP_LOAD, 16'hFFFF, 12'hFFF, 12'hFFF);
      queue_request(bcs_pkg::OP_LOAD, 16'h0000, 12'h000, 12'h000);
      queue_request(bcs_pkg::OP_LOAD, 16'h5A5A, 12'hFFF, 12'h001);
      queue_request(bcs_pkg::OP_LOAD, 16'hA5A5, 12'hFFF, 12'h001);
      queue_request(bcs_pkg::OP_LOAD, 16'h0001, 12'h064, 12'h000);
      queue_request(bcs_pkg::OP_LOAD, 16'h0002, 12'h064, 12'h7FF);
      queue_request(bcs_pkg::OP_LOAD, 16'h8000, 12'h000, 12'hFFF);
      repeat (8) queue_request(bcs_pkg::OP_TAKE, 16'hFFFF, 12'hFFF, 12'hFFF);
      queue_request(bcs_pkg::OP_CLEAR, 16'hFFFF, 12'hFFF, 12'hFFF);
      queue_request(bcs_pkg::OP_TAKE, 16'h0000, 12'h000, 12'h000);
      queue_request(bcs_pkg::OP_LOAD, 16'h1234, 12'h800, 12'h800);
      queue_request(OP_IGNORED, 16'h0000, 12'h000, 12'h000);
      queue_request(bcs_pkg::OP_LOAD, 16'h4321, 12'h800, 12'h800);
      queue_request(bcs_pkg::OP_TAKE, 16'h0000, 12'h000, 12'h000);
      queue_request(bcs_pkg::OP_CLEAR, 16'h0000, 12'h000, 12'h000);
      queue_request(bcs_pkg::OP_TAKE, 16'h0000, 12'h000, 12'h000);

      while (counted_items < TARGET_ITEMS) begin
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 6))
               queue_request(2'($urandom_range(0, 3)), 16'($urandom), 12'($urandom),
                             12'($urandom));
         end else begin
            tight = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) == 0)
               loads = $urandom_range(bcs_pkg::MAX_CAPTURES - 8, bcs_pkg::MAX_CAPTURES + 6);
            else
               loads = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
               queue_request(bcs_pkg::OP_CLEAR, 16'($urandom), 12'($urandom),
                             12'($urandom));
            repeat (loads) queue_random_load(tight);
            repeat ($urandom_range(1, loads)) queue_random_take();
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 4)) queue_random_load(tight);
            repeat ($urandom_range(0, loads + 2)) queue_random_take();
         end
      end
   endfunction

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            track_request(current_request);
            accepted_items++;
            if (request_queue.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 10);
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               current_request = request_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.operation <= current_request.op;
               req_bus.move_code <= current_request.move;
               req_bus.victim_gain <= current_request.gain;
               req_bus.attacker_value <= current_request.aggr;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with one long hold once a take is in flight
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!long_hold_done && accepted_items >= total_items / 3 &&
                   expected_picks.size() > 0) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (accepted_items < total_items - TAIL_ITEMS &&
                   $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(1, 10) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // result checking
   always @(posedge clock) begin
      capture_pick_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         picks_seen++;
         if (expected_picks.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, expected none, actual move %0h gain %0h",
                     $time, rsp_bus.chosen_move, rsp_bus.chosen_gain);
         end else begin
            want = expected_picks.pop_front();
            if (!want.found)
               empty_picks++;
            check_field("chosen_move", want.move, rsp_bus.chosen_move);
            check_field("chosen_gain", 16'(want.gain), 16'(rsp_bus.chosen_gain));
            check_field("found", 16'(want.found), 16'(rsp_bus.found));
            check_field("store_full", 16'(want.full), 16'(rsp_bus.store_full));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = bcs_pkg::OP_CLEAR;
      req_bus.move_code = '0;
      req_bus.victim_gain = '0;
      req_bus.attacker_value = '0;
      rsp_bus.ready = 1'b0;
      shadow_count = 0;
      shadow_taken = 0;
      shadow_overflow = 1'b0;
      long_hold_done = 1'b0;
      build_stimulus();
      total_items = request_queue.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (accepted_items < total_items) @(posedge clock);
      while (expected_picks.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run: %0d transactions sent, %0d takes answered, %0d of them on an empty list",
               accepted_items, picks_seen, empty_picks);
      $display("run: %0d loads dropped on a full store, one long receiver stall of %0d cycles",
               dropped_loads, LONG_HOLD);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
design/bcs_pkg.sv
design/bcs_req_if.sv
design/bcs_rsp_if.sv
design/bcs_cell.sv
design/best_capture_selector_core.sv
tb/tb_best_capture_selector_core.sv
